// File: hw/rtl/pcs_pkg.sv
// Package for the PCI class search sequencer: bus walk limits, offsets,
// result kind codes and the result record shared by the walker and the top level.
// No dependencies.
`default_nettype none

package pcs_pkg;

    // Extent of the walk.
    localparam int BUS_COUNT       = 256;
    localparam int DEVICES_PER_BUS = 32;
    localparam int MAX_FUNCTIONS   = 8;

    localparam logic [7:0] BUS_LAST  = 8'(BUS_COUNT - 1);
    localparam logic [4:0] DEV_LAST  = 5'(DEVICES_PER_BUS - 1);
    localparam logic [2:0] FUNC_LAST = 3'(MAX_FUNCTIONS - 1);

    // Configuration space fields.
    localparam logic [15:0] VENDOR_ABSENT = 16'hFFFF;
    localparam logic [7:0]  HDR_MULTI     = 8'h80;
    localparam logic [7:0]  OFF_ID        = 8'h00;
    localparam logic [7:0]  OFF_CLASS     = 8'h08;
    localparam logic [7:0]  OFF_HDR       = 8'h0C;
    localparam logic [7:0]  OFF_ALIGN     = 8'hFC;

    // Input word kinds.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_MATCH_CLASS     = 2'd0;
    localparam logic [1:0] REG_MATCH_SUBCLASS  = 2'd1;
    localparam logic [1:0] REG_MATCH_INTERFACE = 2'd2;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_READ      = 2'd0,
        KIND_FOUND     = 2'd1,
        KIND_EXHAUSTED = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t        kind;
        logic [31:0]  address;
        logic [7:0]   bus;
        logic [4:0]   dev;
        logic [2:0]   func;
        logic [15:0]  vendor;
        logic [15:0]  device;
        logic [6:0]   header;
        logic [7:0]   revision;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/pci_class_search_sequencer.sv
// Top level of the PCI class search sequencer: input word register, output
// word register and the stream ports. Depends on pcs_pkg and pcs_walker.
`default_nettype none

// The sequencer walks every bus, device and function looking for the first
// function whose class, subclass and programming interface equal the three
// match registers. Send a start word (tuser = 0) to begin; every output word
// of kind 0 is a configuration read address, and the host answers each one
// with a data word (tuser = 1) carrying the dword read. The walk ends with a
// found word (kind 1, with location, IDs, header type and revision) or an
// exhausted word (kind 2). Data words that arrive while idle are dropped, and
// a start word while busy restarts the search. The block takes one word per
// clock cycle while the output register is free or being drained: a word is
// held in the input register, the walker decides the next step from it
// combinationally and the result is registered in the output register. A
// word waits in the input register while an untaken result is held. The
// rate is set by the single walker step per cycle and by the output
// register, which keeps accepting while the consumer takes each result.
// Match registers are to be written only while the block is idle.
module pci_class_search_sequencer
    import pcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // read_data[31:0]
    input  wire logic        s_tuser,    // req_type[0]
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // cfg_address[31:0], bus_num[39:32], dev_num[44:40], func_num[47:45],
    // vendor_ident[63:48], device_ident[79:64], header_kind[86:80],
    // revision_ident[94:87], zero pad[95]
    output logic [95:0]      m_tdata,
    output logic [1:0]       m_tuser,    // out_kind[1:0]
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic        in_valid_reg;
    logic        in_req_reg;
    logic [31:0] in_data_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        fire;
    logic        res_valid;
    result_t     res;

    // The held word is processed when the output register is free or draining.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    pcs_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .req_type  (in_req_reg),
        .read_data (in_data_reg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= res_valid;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {1'b0, out_reg.revision, out_reg.header, out_reg.device,
                       out_reg.vendor, out_reg.func, out_reg.dev, out_reg.bus,
                       out_reg.address};

endmodule

`default_nettype wire

// File: hw/rtl/pcs_walker.sv
// Search state of the PCI class search sequencer: counters, phase, match
// registers and the per-word decision logic. Depends on pcs_pkg.
`default_nettype none

module pcs_walker
    import pcs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic        req_type,
    input  wire logic [31:0] read_data,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             res_valid,
    output result_t          res
);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PROBE_ID  = 3'd1,
        PH_PROBE_HDR = 3'd2,
        PH_FUNC_ID   = 3'd3,
        PH_CLASS     = 3'd4,
        PH_MATCH_HDR = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        busy_reg, busy_next;
    logic [7:0]  bus_reg, bus_next;
    logic [4:0]  dev_reg, dev_next;
    logic [2:0]  func_reg, func_next;
    logic        multi_reg, multi_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] class_reg, class_next;
    logic [7:0]  match_class_reg, match_subclass_reg, match_interface_reg;

    logic        emit_rd;
    logic [7:0]  offset;
    logic        do_next_func;
    logic        do_next_dev;

    always_comb
    begin
        phase_next   = phase_reg;
        busy_next    = busy_reg;
        bus_next     = bus_reg;
        dev_next     = dev_reg;
        func_next    = func_reg;
        multi_next   = multi_reg;
        id_next      = id_reg;
        class_next   = class_reg;
        emit_rd      = 1'b0;
        offset       = OFF_ID;
        do_next_func = 1'b0;
        do_next_dev  = 1'b0;
        res_valid    = 1'b0;
        res          = '0;

        if (req_type == REQ_START)
        begin
            busy_next  = 1'b1;
            bus_next   = '0;
            dev_next   = '0;
            func_next  = '0;
            multi_next = 1'b0;
            phase_next = PH_PROBE_ID;
            emit_rd    = 1'b1;
            offset     = OFF_ID;
        end
        else if (busy_reg)
        begin
            case (phase_reg)
                PH_PROBE_ID:
                begin
                    if (read_data[15:0] == VENDOR_ABSENT)
                    begin
                        do_next_dev = 1'b1;
                    end
                    else
                    begin
                        id_next    = read_data;
                        phase_next = PH_PROBE_HDR;
                        emit_rd    = 1'b1;
                        offset     = OFF_HDR;
                    end
                end
                PH_PROBE_HDR:
                begin
                    multi_next = (read_data[23:16] & HDR_MULTI) != 8'h00;
                    func_next  = '0;
                    phase_next = PH_CLASS;
                    emit_rd    = 1'b1;
                    offset     = OFF_CLASS;
                end
                PH_FUNC_ID:
                begin
                    if (read_data[15:0] == VENDOR_ABSENT)
                    begin
                        do_next_func = 1'b1;
                    end
                    else
                    begin
                        id_next    = read_data;
                        phase_next = PH_CLASS;
                        emit_rd    = 1'b1;
                        offset     = OFF_CLASS;
                    end
                end
                PH_CLASS:
                begin
                    class_next = read_data;
                    if (read_data[31:24] == match_class_reg &&
                        read_data[23:16] == match_subclass_reg &&
                        read_data[15:8] == match_interface_reg)
                    begin
                        phase_next = PH_MATCH_HDR;
                        emit_rd    = 1'b1;
                        offset     = OFF_HDR;
                    end
                    else
                    begin
                        do_next_func = 1'b1;
                    end
                end
                PH_MATCH_HDR:
                begin
                    res_valid    = 1'b1;
                    res.kind     = KIND_FOUND;
                    res.bus      = bus_reg;
                    res.dev      = dev_reg;
                    res.func     = func_reg;
                    res.vendor   = id_reg[15:0];
                    res.device   = id_reg[31:16];
                    res.header   = read_data[22:16];
                    res.revision = class_reg[7:0];
                    busy_next    = 1'b0;
                    phase_next   = PH_IDLE;
                end
                default:
                begin
                    busy_next  = 1'b0;
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Step to the next function of a multifunction device, else the next device.
        if (do_next_func)
        begin
            if (multi_reg && func_reg < FUNC_LAST)
            begin
                func_next  = func_reg + 3'd1;
                phase_next = PH_FUNC_ID;
                emit_rd    = 1'b1;
                offset     = OFF_ID;
            end
            else
            begin
                do_next_dev = 1'b1;
            end
        end

        if (do_next_dev)
        begin
            func_next  = '0;
            multi_next = 1'b0;
            phase_next = PH_PROBE_ID;
            emit_rd    = 1'b1;
            offset     = OFF_ID;
            if (dev_reg < DEV_LAST)
            begin
                dev_next = dev_reg + 5'd1;
            end
            else
            begin
                dev_next = '0;
                if (bus_reg < BUS_LAST)
                begin
                    bus_next = bus_reg + 8'd1;
                end
                else
                begin
                    emit_rd    = 1'b0;
                    busy_next  = 1'b0;
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res.kind   = KIND_EXHAUSTED;
                end
            end
        end

        // A read request always carries the counters as updated by this word.
        if (emit_rd)
        begin
            res_valid   = 1'b1;
            res.kind    = KIND_READ;
            res.address = {1'b1, 7'b0, bus_next, dev_next, func_next, offset & OFF_ALIGN};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            busy_reg            <= 1'b0;
            bus_reg             <= '0;
            dev_reg             <= '0;
            func_reg            <= '0;
            multi_reg           <= 1'b0;
            id_reg              <= '0;
            class_reg           <= '0;
            match_class_reg     <= '0;
            match_subclass_reg  <= '0;
            match_interface_reg <= '0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                busy_reg  <= busy_next;
                bus_reg   <= bus_next;
                dev_reg   <= dev_next;
                func_reg  <= func_next;
                multi_reg <= multi_next;
                id_reg    <= id_next;
                class_reg <= class_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MATCH_CLASS:     match_class_reg     <= cfg_data;
                    REG_MATCH_SUBCLASS:  match_subclass_reg  <= cfg_data;
                    REG_MATCH_INTERFACE: match_interface_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
